// File: design/m3inv_pkg.sv
package m3inv_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // threshold register: width and value after reset
  localparam int THR_W = 31;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  localparam int NUM_ELEM = 9;

endpackage

// File: design/matrix3x3_inverse_top.sv
// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------------
// request   | start (in), busy (out)     | a11 .. a33, signed Q.FRAC_BITS
// result    | done (out), one-cycle mark | inv11 .. inv33, nonsingular
// config    | det_threshold_we (in)      | det_threshold, 31 bits
//
// one request is taken every cycle; busy is always low
// done marks the result of each start once it has passed, in order, the
// six input-to-determinant stages, the divider setup stage, one stage per quotient bit
// in the nine long dividers, and the output register
// rst is synchronous and clears the valid bits and the threshold (to 1)
// nothing stalls: results leave on done whether or not the receiver looks
module matrix3x3_inverse_top #(
  parameter int DATA_WIDTH = m3inv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [DATA_WIDTH-1:0]       a11,
  input  logic signed [DATA_WIDTH-1:0]       a12,
  input  logic signed [DATA_WIDTH-1:0]       a13,
  input  logic signed [DATA_WIDTH-1:0]       a21,
  input  logic signed [DATA_WIDTH-1:0]       a22,
  input  logic signed [DATA_WIDTH-1:0]       a23,
  input  logic signed [DATA_WIDTH-1:0]       a31,
  input  logic signed [DATA_WIDTH-1:0]       a32,
  input  logic signed [DATA_WIDTH-1:0]       a33,
  input  logic                               det_threshold_we,
  input  logic [m3inv_pkg::THR_W-1:0]        det_threshold,
  output logic                               done,
  output logic signed [DATA_WIDTH-1:0]       inv11,
  output logic signed [DATA_WIDTH-1:0]       inv12,
  output logic signed [DATA_WIDTH-1:0]       inv13,
  output logic signed [DATA_WIDTH-1:0]       inv21,
  output logic signed [DATA_WIDTH-1:0]       inv22,
  output logic signed [DATA_WIDTH-1:0]       inv23,
  output logic signed [DATA_WIDTH-1:0]       inv31,
  output logic signed [DATA_WIDTH-1:0]       inv32,
  output logic signed [DATA_WIDTH-1:0]       inv33,
  output logic                               nonsingular
);

  localparam int DW = DATA_WIDTH;
  localparam int NE = m3inv_pkg::NUM_ELEM;
  localparam int PW = 2 * DW;              // element product
  localparam int CW = 2 * DW + 1;          // cofactor
  localparam int LW = DW + 1;              // low slice of a cofactor
  localparam int HW = CW - LW;             // high slice of a cofactor
  localparam int DETW = 3 * DW + 3;        // determinant
  localparam int NUMW = CW + 2 * FRAC_BITS + 2;
  localparam int DENW = DETW + 1 + DW;
  localparam int WW = (NUMW > DENW) ? NUMW : DENW;
  localparam int LAT = DW + 8;

  logic [m3inv_pkg::THR_W-1:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= m3inv_pkg::THR_RESET;
    end else if (det_threshold_we) begin
      thr <= det_threshold;
    end
  end

  assign busy = 1'b0;

  // stage 1: input register
  logic                 v1;
  logic signed [DW-1:0] e1 [0:NE-1];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    e1[0] <= a11; e1[1] <= a12; e1[2] <= a13;
    e1[3] <= a21; e1[4] <= a22; e1[5] <= a23;
    e1[6] <= a31; e1[7] <= a32; e1[8] <= a33;
  end

  // stage 2: the eighteen element products
  logic                 v2;
  logic signed [DW-1:0] e2 [0:NE-1];
  logic signed [PW-1:0] pr [0:2*NE-1];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    e2 <= e1;
    pr[0]  <= e1[4] * e1[8]; pr[1]  <= e1[5] * e1[7];
    pr[2]  <= e1[2] * e1[7]; pr[3]  <= e1[1] * e1[8];
    pr[4]  <= e1[1] * e1[5]; pr[5]  <= e1[4] * e1[2];
    pr[6]  <= e1[5] * e1[6]; pr[7]  <= e1[3] * e1[8];
    pr[8]  <= e1[0] * e1[8]; pr[9]  <= e1[2] * e1[6];
    pr[10] <= e1[2] * e1[3]; pr[11] <= e1[0] * e1[5];
    pr[12] <= e1[3] * e1[7]; pr[13] <= e1[6] * e1[4];
    pr[14] <= e1[1] * e1[6]; pr[15] <= e1[0] * e1[7];
    pr[16] <= e1[0] * e1[4]; pr[17] <= e1[1] * e1[3];
  end

  // stage 3: cofactors (adjugate, row by row)
  logic                 v3;
  logic signed [DW-1:0] e3 [0:2];
  logic signed [CW-1:0] cof3 [0:NE-1];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    for (int j = 0; j < 3; j++) e3[j] <= e2[j];
    for (int j = 0; j < NE; j++) begin
      cof3[j] <= CW'(pr[2*j]) - CW'(pr[2*j+1]);
    end
  end

  // stage 4: first row times cofactors, each split into two partial products
  logic                     v4;
  logic signed [CW-1:0]     cof4 [0:NE-1];
  logic signed [DW+LW:0]    plo [0:2];
  logic signed [DW+HW-1:0]  phi [0:2];
  logic signed [CW-1:0]     dcof [0:2];

  assign dcof[0] = cof3[0];
  assign dcof[1] = cof3[3];
  assign dcof[2] = cof3[6];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    cof4 <= cof3;
    for (int j = 0; j < 3; j++) begin
      plo[j] <= e3[j] * $signed({1'b0, dcof[j][LW-1:0]});
      phi[j] <= e3[j] * $signed(dcof[j][CW-1:LW]);
    end
  end

  // stage 5: recombine partial products
  logic                   v5;
  logic signed [CW-1:0]   cof5 [0:NE-1];
  logic signed [DETW-1:0] term [0:2];

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    cof5 <= cof4;
    for (int j = 0; j < 3; j++) begin
      term[j] <= (DETW'(phi[j]) <<< LW) + DETW'(plo[j]);
    end
  end

  // stage 6: determinant
  logic                   v6;
  logic signed [CW-1:0]   cof6 [0:NE-1];
  logic signed [DETW-1:0] det;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    cof6 <= cof5;
    det <= term[0] + term[1] + term[2];
  end

  // divider setup: rounded quotient is (2|c|*2^(2F) + |d|) / (2|d|)
  logic [DETW-1:0] absd;
  logic [WW-1:0]   den0;
  logic [WW-1:0]   num0 [0:NE-1];
  logic            neg0 [0:NE-1];
  logic            sing0;

  always_comb begin
    absd = det[DETW-1] ? DETW'(-det) : DETW'(det);
    den0 = WW'(absd) << 1;
    sing0 = (absd == '0) || (WW'(absd) < (WW'(thr) << (2 * FRAC_BITS)));
    for (int j = 0; j < NE; j++) begin
      num0[j] = (WW'(cof6[j][CW-1] ? CW'(-cof6[j]) : CW'(cof6[j])) << (2 * FRAC_BITS + 1))
                + WW'(absd);
      neg0[j] = cof6[j][CW-1] ^ det[DETW-1];
    end
  end

  logic          dv_v    [0:DW];
  logic          dv_sing [0:DW];
  logic [WW-1:0] dv_den  [0:DW];
  logic [WW-1:0] dv_rem  [0:DW][0:NE-1];
  logic [DW-1:0] dv_q    [0:DW][0:NE-1];
  logic          dv_ovf  [0:DW][0:NE-1];
  logic          dv_neg  [0:DW][0:NE-1];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else dv_v[0] <= v6;
    dv_sing[0] <= sing0;
    dv_den[0] <= den0;
    for (int j = 0; j < NE; j++) begin
      dv_rem[0][j] <= num0[j];
      dv_q[0][j] <= '0;
      dv_ovf[0][j] <= 1'b0;
      dv_neg[0][j] <= neg0[j];
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= DW; k++) begin : g_div
    localparam int B = DW - k;
    always_ff @(posedge clk) begin
      if (rst) dv_v[k] <= 1'b0;
      else dv_v[k] <= dv_v[k-1];
      dv_sing[k] <= dv_sing[k-1];
      dv_den[k] <= dv_den[k-1];
      for (int j = 0; j < NE; j++) begin
        dv_neg[k][j] <= dv_neg[k-1][j];
        if (dv_rem[k-1][j] >= (dv_den[k-1] << B)) begin
          dv_rem[k][j] <= dv_rem[k-1][j] - (dv_den[k-1] << B);
          dv_q[k][j] <= dv_q[k-1][j] | (DW'(1) << B);
        end else begin
          dv_rem[k][j] <= dv_rem[k-1][j];
          dv_q[k][j] <= dv_q[k-1][j];
        end
      end
    end
    if (k == 1) begin : g_ovf
      // quotient of 2^DW or more saturates whatever the low bits say
      always_ff @(posedge clk) begin
        for (int j = 0; j < NE; j++) begin
          dv_ovf[k][j] <= dv_rem[k-1][j] >= (dv_den[k-1] << DW);
        end
      end
    end else begin : g_carry
      always_ff @(posedge clk) begin
        for (int j = 0; j < NE; j++) dv_ovf[k][j] <= dv_ovf[k-1][j];
      end
    end
  end

  // output stage: sign, saturation, singular zeroing
  localparam logic [DW-1:0] HALF = DW'(1) << (DW - 1);

  logic          done_r;
  logic          nsg_r;
  logic [DW-1:0] inv_r [0:NE-1];
  logic [DW-1:0] inv_next [0:NE-1];

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      if (dv_sing[DW]) begin
        inv_next[j] = '0;
      end else if (dv_neg[DW][j]) begin
        if (dv_ovf[DW][j] || (dv_q[DW][j] > HALF)) inv_next[j] = HALF;
        else inv_next[j] = -dv_q[DW][j];
      end else begin
        if (dv_ovf[DW][j] || dv_q[DW][j][DW-1]) inv_next[j] = HALF - DW'(1);
        else inv_next[j] = dv_q[DW][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done_r <= 1'b0;
    else done_r <= dv_v[DW];
    nsg_r <= !dv_sing[DW];
    inv_r <= inv_next;
  end

  assign done = done_r;
  assign nonsingular = nsg_r;
  assign inv11 = inv_r[0];
  assign inv12 = inv_r[1];
  assign inv13 = inv_r[2];
  assign inv21 = inv_r[3];
  assign inv22 = inv_r[4];
  assign inv23 = inv_r[5];
  assign inv31 = inv_r[6];
  assign inv32 = inv_r[7];
  assign inv33 = inv_r[8];

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a request");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !nonsingular) |-> (inv11 == '0 && inv22 == '0 && inv33 == '0
                                && inv13 == '0 && inv31 == '0))
    else $error("singular result not zeroed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");
`endif

endmodule
